[src/page_map_ftl_greedy_gc_top_defines.svh]
// Assertion macros of the page-mapped translation block.
// Included by files that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef PAGE_MAP_FTL_GREEDY_GC_TOP_DEFINES_SVH
`define PAGE_MAP_FTL_GREEDY_GC_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PMFTL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PMFTL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pmftl_pkg.sv]
// Package of the page-mapped translation block: sizes, codes, types.
// No dependencies; the interfaces, front end, back end, top and testbench import it.
package pmftl_pkg;

    localparam int PAGES_PER_BLOCK = 16;
    localparam int NUM_BLOCKS      = 64;
    localparam int NUM_PAGES       = 1024;

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int OFF_W  = $clog2(PAGES_PER_BLOCK);
    localparam int CNT_W  = $clog2(PAGES_PER_BLOCK + 1);
    localparam int WP_W   = PAGE_W + 1;
    localparam int QDEPTH = 2;

    localparam int CMD_W  = 2;
    localparam int OP_W   = 3;
    localparam int LP_W   = 10;
    localparam int PP_W   = 10;
    localparam int SLOT_W = 4;

    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [OP_W-1:0] OP_HOST_READ = 3'd0;
    localparam logic [OP_W-1:0] OP_UNMAPPED  = 3'd1;
    localparam logic [OP_W-1:0] OP_GC_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE     = 3'd3;
    localparam logic [OP_W-1:0] OP_GC_PROG   = 3'd4;
    localparam logic [OP_W-1:0] OP_HOST_PROG = 3'd5;
    localparam logic [OP_W-1:0] OP_REMOVED   = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] lp;
    } t_req;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
    } t_fm_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GET,
        S_RM1,
        S_SET_A,
        S_SET_B,
        S_DROP_PV,
        S_DROP_IC,
        S_RM_DONE,
        S_SET_E,
        S_GC_SCAN,
        S_GC_RD_A,
        S_GC_RD_B,
        S_GC_ERASE,
        S_GC_PROG
    } t_state;

endpackage

[src/pmftl_ifs.sv]
// Request and result channel interfaces of the page-mapped translation block.
// Depends on pmftl_pkg for field widths.
interface pmftl_req_if import pmftl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [LP_W-1:0]   logical_page;

    modport source(output valid, output command, output logical_page, input ready);
    modport sink(input valid, input command, input logical_page, output ready);
endinterface

interface pmftl_rsp_if import pmftl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [PP_W-1:0]   physical_page;
    logic [SLOT_W-1:0] buffer_slot;
    logic [LP_W-1:0]   moved_logical_page;
    logic              last;

    modport source(output valid, output op, output physical_page, output buffer_slot,
                   output moved_logical_page, output last, input ready);
    modport sink(input valid, input op, input physical_page, input buffer_slot,
                 input moved_logical_page, input last, output ready);
endinterface

[src/pmftl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[src/pmftl_front.sv]
// Front end: accepts requests, drops command code three and queues the rest.
// Depends on pmftl_pkg and the request channel interface.
module pmftl_front import pmftl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmftl_req_if.sink   i_req,
    output logic        o_q_valid,
    output t_req        o_q_item,
    input  logic        i_q_pop
);
    localparam int QP_W = $clog2(QDEPTH);

    t_req                 r_mem [QDEPTH];
    logic [QP_W-1:0]      r_wr, r_rd;
    logic [QP_W:0]        r_cnt;
    logic                 push;

    assign i_req.ready = (r_cnt != (QP_W+1)'(QDEPTH));
    // Command code three carries no work and is swallowed here.
    assign push = i_req.valid && i_req.ready && (i_req.command != CMD_NONE);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QP_W'(QDEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= (r_rd == QP_W'(QDEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QP_W+1)'(push) - (QP_W+1)'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{cmd: i_req.command, lp: PAGE_W'(i_req.logical_page)};
        end
    end
endmodule

[src/pmftl_back.sv]
// Back end: sequencer that executes queued requests against the map tables.
// Depends on pmftl_pkg, pmftl_ram, the result interface and the assertion macros.
`include "page_map_ftl_greedy_gc_top_defines.svh"
module pmftl_back import pmftl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_req        i_q_item,
    output logic        o_q_pop,
    pmftl_rsp_if.source o_rsp
);
    t_state r_state, n_state;

    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [PAGE_W-1:0]  r_lp, n_lp;
    logic [PAGE_W-1:0]  r_old, n_old;
    logic [WP_W-1:0]    r_wp, n_wp;
    logic [PAGE_W-1:0]  r_rsv, n_rsv;
    logic               r_wrapped, n_wrapped;
    logic [PAGE_W-1:0]  r_clr, n_clr;
    logic [BLK_W:0]     r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [BLK_W-1:0]   r_pblk, n_pblk;
    logic [CNT_W-1:0]   r_best, n_best;
    logic [BLK_W-1:0]   r_victim, n_victim;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [OFF_W:0]     r_slot_cnt, n_slot_cnt;
    logic [OFF_W:0]     r_prog, n_prog;
    logic [WP_W-1:0]    r_rp, n_rp;
    logic [PAGE_W-1:0]  r_owner [PAGES_PER_BLOCK];

    logic               owner_we;

    // Output register.
    logic               r_out_valid;
    logic [OP_W-1:0]    r_out_op;
    logic [PP_W-1:0]    r_out_page;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [LP_W-1:0]    r_out_lp;
    logic               r_out_last;
    logic               can_emit, emit, e_last;
    logic [OP_W-1:0]    e_op;
    logic [PAGE_W-1:0]  e_page, e_lp;
    logic [OFF_W-1:0]   e_slot;

    // Table ports.
    logic               fm_we, fm_re, pv_we, pv_re, pv_wdata, pv_rdata;
    logic [PAGE_W-1:0]  fm_waddr, fm_raddr, pv_waddr, pv_raddr;
    t_fm_entry          fm_wdata, fm_rdata;
    logic               rm_we, rm_re;
    logic [PAGE_W-1:0]  rm_waddr, rm_raddr, rm_wdata, rm_rdata;
    logic               ic_we, ic_re;
    logic [BLK_W-1:0]   ic_waddr, ic_raddr;
    logic [CNT_W-1:0]   ic_wdata, ic_rdata;

    logic               gc_due;
    logic [PAGE_W-1:0]  gc_page, base, prog_page, prog_owner;
    t_state             drop_next;

    pmftl_ram #(.WIDTH($bits(t_fm_entry)), .DEPTH(NUM_PAGES)) u_fm (
        .i_clk(i_clk), .i_we(fm_we), .i_waddr(fm_waddr), .i_wdata(fm_wdata),
        .i_re(fm_re), .i_raddr(fm_raddr), .o_rdata(fm_rdata));
    pmftl_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_pv (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_re(pv_re), .i_raddr(pv_raddr), .o_rdata(pv_rdata));
    pmftl_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_rm (
        .i_clk(i_clk), .i_we(rm_we), .i_waddr(rm_waddr), .i_wdata(rm_wdata),
        .i_re(rm_re), .i_raddr(rm_raddr), .o_rdata(rm_rdata));
    pmftl_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BLOCKS)) u_ic (
        .i_clk(i_clk), .i_we(ic_we), .i_waddr(ic_waddr), .i_wdata(ic_wdata),
        .i_re(ic_re), .i_raddr(ic_raddr), .o_rdata(ic_rdata));

    assign can_emit   = !r_out_valid || o_rsp.ready;
    assign gc_due     = (!r_wrapped && (r_wp >= WP_W'(NUM_PAGES)))
                      || (r_wrapped && (r_wp[OFF_W-1:0] == '0));
    assign base       = {r_victim, {OFF_W{1'b0}}};
    assign gc_page    = {r_victim, r_off};
    assign prog_page  = r_rp[PAGE_W-1:0];
    assign prog_owner = r_owner[r_prog[OFF_W-1:0]];
    assign drop_next  = (r_cmd == CMD_REMOVE) ? S_RM_DONE : S_SET_E;

    always_comb begin
        n_state = r_state;   n_cmd = r_cmd;       n_lp = r_lp;
        n_old = r_old;       n_wp = r_wp;         n_rsv = r_rsv;
        n_wrapped = r_wrapped; n_clr = r_clr;     n_idx = r_idx;
        n_pend = r_pend;     n_pblk = r_pblk;     n_best = r_best;
        n_victim = r_victim; n_off = r_off;       n_slot_cnt = r_slot_cnt;
        n_prog = r_prog;     n_rp = r_rp;
        o_q_pop = 1'b0;      owner_we = 1'b0;
        emit = 1'b0;  e_op = OP_HOST_READ; e_page = '0; e_slot = '0; e_lp = '0;
        e_last = 1'b0;
        fm_we = 1'b0; fm_waddr = r_lp; fm_wdata = '0; fm_re = 1'b0; fm_raddr = r_lp;
        pv_we = 1'b0; pv_waddr = r_old; pv_wdata = 1'b0; pv_re = 1'b0; pv_raddr = r_old;
        rm_we = 1'b0; rm_waddr = r_old; rm_wdata = '0; rm_re = 1'b0; rm_raddr = gc_page;
        ic_we = 1'b0; ic_waddr = r_old[PAGE_W-1:OFF_W]; ic_wdata = '0;
        ic_re = 1'b0; ic_raddr = r_old[PAGE_W-1:OFF_W];

        case (r_state)
            S_CLEAR: begin
                fm_we = 1'b1; fm_waddr = r_clr;
                pv_we = 1'b1; pv_waddr = r_clr;
                if (r_clr < PAGE_W'(NUM_BLOCKS)) begin
                    ic_we = 1'b1; ic_waddr = r_clr[BLK_W-1:0];
                end
                if (r_clr == PAGE_W'(NUM_PAGES-1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd = i_q_item.cmd;
                    n_lp = i_q_item.lp;
                    fm_re = 1'b1; fm_raddr = i_q_item.lp;
                    case (i_q_item.cmd)
                        CMD_GET: n_state = S_GET;
                        CMD_REMOVE: n_state = S_RM1;
                        CMD_SET: begin
                            if (gc_due) begin
                                n_idx = '0; n_pend = 1'b0; n_best = '0; n_victim = '0;
                                n_state = S_GC_SCAN;
                            end else begin
                                n_state = S_SET_B;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_GET: begin
                if (can_emit) begin
                    emit = 1'b1; e_last = 1'b1;
                    e_op = fm_rdata.valid ? OP_HOST_READ : OP_UNMAPPED;
                    e_page = fm_rdata.valid ? fm_rdata.page : '0;
                    n_state = S_IDLE;
                end
            end
            S_RM1: begin
                if (fm_rdata.valid) begin
                    n_old = fm_rdata.page;
                    pv_re = 1'b1; pv_raddr = fm_rdata.page;
                    fm_we = 1'b1; fm_waddr = r_lp;
                    rm_we = 1'b1; rm_waddr = fm_rdata.page;
                    n_state = S_DROP_PV;
                end else begin
                    n_old = '0;
                    n_state = S_RM_DONE;
                end
            end
            S_SET_A: begin
                fm_re = 1'b1;
                n_state = S_SET_B;
            end
            S_SET_B: begin
                if (fm_rdata.valid) begin
                    n_old = fm_rdata.page;
                    pv_re = 1'b1; pv_raddr = fm_rdata.page;
                    n_state = S_DROP_PV;
                end else begin
                    n_state = S_SET_E;
                end
            end
            S_DROP_PV: begin
                if (pv_rdata) begin
                    pv_we = 1'b1;
                    ic_re = 1'b1;
                    n_state = S_DROP_IC;
                end else begin
                    n_state = drop_next;
                end
            end
            S_DROP_IC: begin
                // Block counts saturate at a full block.
                if (ic_rdata < CNT_W'(PAGES_PER_BLOCK)) begin
                    ic_we = 1'b1; ic_wdata = ic_rdata + 1'b1;
                end
                n_state = drop_next;
            end
            S_RM_DONE: begin
                if (can_emit) begin
                    emit = 1'b1; e_last = 1'b1; e_op = OP_REMOVED; e_page = r_old;
                    n_state = S_IDLE;
                end
            end
            S_SET_E: begin
                if (can_emit) begin
                    emit = 1'b1; e_last = 1'b1; e_op = OP_HOST_PROG;
                    e_page = r_wp[PAGE_W-1:0];
                    fm_we = 1'b1; fm_wdata = '{valid: 1'b1, page: r_wp[PAGE_W-1:0]};
                    pv_we = 1'b1; pv_waddr = r_wp[PAGE_W-1:0]; pv_wdata = 1'b1;
                    rm_we = 1'b1; rm_waddr = r_wp[PAGE_W-1:0]; rm_wdata = r_lp;
                    n_wp = {1'b0, r_wp[PAGE_W-1:0]} + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_GC_SCAN: begin
                if (r_idx < (BLK_W+1)'(NUM_BLOCKS)) begin
                    ic_re = 1'b1; ic_raddr = r_idx[BLK_W-1:0];
                end
                n_pend = (r_idx < (BLK_W+1)'(NUM_BLOCKS));
                n_pblk = r_idx[BLK_W-1:0];
                n_idx = r_idx + 1'b1;
                // Ties go to the later block.
                if (r_pend && (ic_rdata >= r_best)) begin
                    n_best = ic_rdata;
                    n_victim = r_pblk;
                end
                if (r_idx == (BLK_W+1)'(NUM_BLOCKS)) begin
                    n_off = '0; n_slot_cnt = '0;
                    n_state = S_GC_RD_A;
                end
            end
            S_GC_RD_A: begin
                pv_re = 1'b1; pv_raddr = gc_page;
                rm_re = 1'b1;
                n_state = S_GC_RD_B;
            end
            S_GC_RD_B: begin
                if (!pv_rdata || can_emit) begin
                    if (pv_rdata) begin
                        emit = 1'b1; e_op = OP_GC_READ; e_page = gc_page;
                        e_slot = r_slot_cnt[OFF_W-1:0]; e_lp = rm_rdata;
                        owner_we = 1'b1;
                        pv_we = 1'b1; pv_waddr = gc_page;
                        n_slot_cnt = r_slot_cnt + 1'b1;
                    end
                    if (r_off == OFF_W'(PAGES_PER_BLOCK-1)) begin
                        n_state = S_GC_ERASE;
                    end else begin
                        n_off = r_off + 1'b1;
                        n_state = S_GC_RD_A;
                    end
                end
            end
            S_GC_ERASE: begin
                if (can_emit) begin
                    emit = 1'b1; e_op = OP_ERASE; e_page = base;
                    ic_we = 1'b1; ic_waddr = r_victim;
                    n_rp = {1'b0, r_rsv};
                    n_prog = '0;
                    n_state = S_GC_PROG;
                end
            end
            S_GC_PROG: begin
                if (r_prog == r_slot_cnt) begin
                    n_wp = r_rp;
                    n_rsv = base;
                    n_wrapped = 1'b1;
                    n_state = S_SET_A;
                end else if (can_emit) begin
                    emit = 1'b1; e_op = OP_GC_PROG; e_page = prog_page;
                    e_slot = r_prog[OFF_W-1:0]; e_lp = prog_owner;
                    fm_we = 1'b1; fm_waddr = prog_owner;
                    fm_wdata = '{valid: 1'b1, page: prog_page};
                    pv_we = 1'b1; pv_waddr = prog_page; pv_wdata = 1'b1;
                    rm_we = 1'b1; rm_waddr = prog_page; rm_wdata = prog_owner;
                    n_rp = r_rp + 1'b1;
                    n_prog = r_prog + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_wp        <= WP_W'(PAGES_PER_BLOCK);
            r_rsv       <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_wp      <= n_wp;
            r_rsv     <= n_rsv;
            r_wrapped <= n_wrapped;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;       r_lp <= n_lp;         r_old <= n_old;
        r_idx <= n_idx;       r_pend <= n_pend;     r_pblk <= n_pblk;
        r_best <= n_best;     r_victim <= n_victim; r_off <= n_off;
        r_slot_cnt <= n_slot_cnt; r_prog <= n_prog; r_rp <= n_rp;
        if (owner_we) begin
            r_owner[r_slot_cnt[OFF_W-1:0]] <= rm_rdata;
        end
        if (emit) begin
            r_out_op   <= e_op;
            r_out_page <= PP_W'(e_page);
            r_out_slot <= SLOT_W'(e_slot);
            r_out_lp   <= LP_W'(e_lp);
            r_out_last <= e_last;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.op                 = r_out_op;
    assign o_rsp.physical_page      = r_out_page;
    assign o_rsp.buffer_slot        = r_out_slot;
    assign o_rsp.moved_logical_page = r_out_lp;
    assign o_rsp.last               = r_out_last;

    `PMFTL_ASSERT_IMP(a_prog_bound, r_state == S_GC_PROG, r_prog <= r_slot_cnt,
        "relocation programs outran buffered pages")
    `PMFTL_ASSERT_IMP(a_slot_bound, r_state == S_GC_RD_B, r_slot_cnt <= {1'b0, r_off},
        "more relocation slots than scanned pages")
    `PMFTL_ASSERT_NXT(a_best_mono, r_state == S_GC_SCAN, r_best >= $past(r_best),
        "victim invalid count went down during scan")
endmodule

[src/page_map_ftl_greedy_gc_top.sv]
// Top level of the page-mapped flash translation block with greedy collection.
// Depends on pmftl_pkg, the channel interfaces, pmftl_front and pmftl_back.
//
// This block turns get, set and remove requests on logical pages into flash
// operations: host reads (or an unmapped answer), host programs and remove
// acknowledgements, and, when a set finds the write pointer at the end of
// flash (first time) or on a block boundary (afterwards), a garbage
// collection burst of relocation reads, one erase and relocation programs
// into the reserve block ahead of the host program. The last result of each
// request has last set; command code three is accepted and dropped without
// any result. After reset the block clears its map tables page by page and
// accepts no request into the sequencer in that time, though two requests
// may wait in the input queue. A collection scans the per-block invalid
// counters, reads each page of the victim block, erases it, programs each
// relocated page, ends the relocation and rereads the map. The sequencer
// reads and writes single-write, single-read table memories, so it works one
// request at a time; the output register lets it go on with steps that emit
// nothing while the previous result waits to be taken.
module page_map_ftl_greedy_gc_top import pmftl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmftl_req_if.sink   i_req,
    pmftl_rsp_if.source o_rsp
);
    // Queue between the request front end and the sequencer.
    logic q_valid;
    t_req q_item;
    logic q_pop;

    pmftl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    pmftl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_rsp     (o_rsp)
    );
endmodule

[tb/pmftl_tb_ifs.sv]
// Scoreboard class for the page-mapped translation block testbench.
// Depends on pmftl_pkg for sizes, command codes and result op codes.
package pmftl_tb_pkg;
    import pmftl_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PP_W-1:0]   page;
        logic [SLOT_W-1:0] slot;
        logic [LP_W-1:0]   owner;
        logic              last;
    } t_flash_op;

    class ftl_scoreboard;
        bit            mapped[NUM_PAGES];
        int unsigned   map_to[NUM_PAGES];
        bit            live[NUM_PAGES];
        int unsigned   owner_of[NUM_PAGES];
        int unsigned   stale_cnt[NUM_BLOCKS];
        int unsigned   wptr;
        int unsigned   rptr;
        bit            wrapped;
        t_flash_op     pending[$];
        int            errors;

        function void clear();
            foreach (mapped[i]) begin
                mapped[i] = 0; map_to[i] = 0; live[i] = 0; owner_of[i] = 0;
            end
            foreach (stale_cnt[i]) stale_cnt[i] = 0;
            wptr = PAGES_PER_BLOCK;
            rptr = 0;
            wrapped = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void emit(logic [OP_W-1:0] op, int unsigned pg, int unsigned sl,
                           int unsigned lp);
            t_flash_op r;
            r.op = op; r.page = PP_W'(pg); r.slot = SLOT_W'(sl); r.owner = LP_W'(lp);
            r.last = 0;
            pending.push_back(r);
        endfunction

        function void release_page(int unsigned p);
            int unsigned b;
            p = p % NUM_PAGES;
            if (!live[p]) return;
            live[p] = 0;
            b = p / PAGES_PER_BLOCK;
            if (stale_cnt[b] < PAGES_PER_BLOCK) stale_cnt[b]++;
        endfunction

        // Greedy collection: the last block with the most invalid pages wins.
        function void collect();
            int unsigned victim, best, base, rp, n;
            int unsigned owners[PAGES_PER_BLOCK];
            victim = 0; best = 0; n = 0;
            for (int i = 0; i < NUM_BLOCKS; i++)
                if (stale_cnt[i] >= best) begin
                    victim = i; best = stale_cnt[i];
                end
            base = victim * PAGES_PER_BLOCK;
            for (int i = 0; i < PAGES_PER_BLOCK; i++)
                if (base + i < NUM_PAGES && live[base + i]) begin
                    owners[n] = owner_of[base + i] % NUM_PAGES;
                    emit(OP_GC_READ, base + i, n, owners[n]);
                    live[base + i] = 0;
                    n++;
                end
            emit(OP_ERASE, base, 0, 0);
            rp = rptr;
            for (int i = 0; i < n; i++) begin
                emit(OP_GC_PROG, rp % NUM_PAGES, i, owners[i]);
                mapped[owners[i]] = 1;
                map_to[owners[i]] = rp % NUM_PAGES;
                live[rp % NUM_PAGES] = 1;
                owner_of[rp % NUM_PAGES] = owners[i];
                rp++;
            end
            wptr = rp;
            rptr = base;
            stale_cnt[victim] = 0;
        endfunction

        // Notes one accepted request and queues the results it causes.
        function void note_request(logic [CMD_W-1:0] cmd, logic [LP_W-1:0] lpage);
            int unsigned lp, tgt, old;
            int before_n;
            lp = lpage % NUM_PAGES;
            before_n = pending.size();
            if (cmd == CMD_GET) begin
                if (mapped[lp]) emit(OP_HOST_READ, map_to[lp], 0, 0);
                else emit(OP_UNMAPPED, 0, 0, 0);
            end else if (cmd == CMD_SET) begin
                if (!wrapped && wptr >= NUM_PAGES) begin
                    collect();
                    wrapped = 1;
                end else if (wrapped && wptr % PAGES_PER_BLOCK == 0) begin
                    collect();
                end
                if (mapped[lp]) release_page(map_to[lp]);
                tgt = wptr < NUM_PAGES ? wptr : wptr % NUM_PAGES;
                mapped[lp] = 1;
                map_to[lp] = tgt;
                live[tgt] = 1;
                owner_of[tgt] = lp;
                wptr = tgt + 1;
                emit(OP_HOST_PROG, tgt, 0, 0);
            end else if (cmd == CMD_REMOVE) begin
                old = 0;
                if (mapped[lp]) begin
                    old = map_to[lp] % NUM_PAGES;
                    release_page(old);
                    owner_of[old] = 0;
                    mapped[lp] = 0;
                    map_to[lp] = 0;
                end
                emit(OP_REMOVED, old, 0, 0);
            end
            if (pending.size() > before_n) pending[pending.size() - 1].last = 1;
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(t_flash_op got);
            t_flash_op want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result op=%0d page=%0d slot=%0d lp=%0d last=%0d",
                         $time, got.op, got.page, got.slot, got.owner, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.op !== want.op) begin
                $display("%0t: op expected %0d actual %0d", $time, want.op, got.op);
                errors++;
            end
            if (got.page !== want.page) begin
                $display("%0t: physical_page expected %0d actual %0d",
                         $time, want.page, got.page);
                errors++;
            end
            if (got.slot !== want.slot) begin
                $display("%0t: buffer_slot expected %0d actual %0d",
                         $time, want.slot, got.slot);
                errors++;
            end
            if (got.owner !== want.owner) begin
                $display("%0t: moved_logical_page expected %0d actual %0d",
                         $time, want.owner, got.owner);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass
endpackage

[tb/page_map_ftl_greedy_gc_top_tb.sv]
// Testbench top for the page-mapped translation block with greedy collection.
// Depends on pmftl_pkg, the channel interfaces and pmftl_tb_pkg (scoreboard).
module page_map_ftl_greedy_gc_top_tb;
    import pmftl_pkg::*;
    import pmftl_tb_pkg::*;

    // The slowest correct item is a set with a collection: a counter scan and a
    // read per victim page, then up to 34 results that each can wait out a sink
    // stall. After reset the block clears its tables. The
    // watchdog only counts cycles with no handshake, so QUIET_LIMIT is several times
    // the longest quiet stretch.
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;

    pmftl_req_if req_ch();
    pmftl_rsp_if rsp_ch();

    page_map_ftl_greedy_gc_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    ftl_scoreboard flash_book;
    int quiet_cycles = 0;
    bit sink_stalls;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        flash_book = new();
        flash_book.clear();
    end

    // Watchdog: any handshake on either channel resets the count.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: every accepted item goes straight to the scoreboard. Ready
    // is lowered for a random number of cycles before each item, except during
    // stretches where the sender asks for none.
    initial begin
        int wait_n;
        t_flash_op got;
        rsp_ch.ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_n = sink_stalls ? $urandom_range(0, 14) : 0;
            if (wait_n > 0) begin
                rsp_ch.ready <= 0;
                repeat (wait_n) @(posedge i_clk);
            end
            rsp_ch.ready <= 1;
            @(posedge i_clk iff rsp_ch.valid);
            got.op = rsp_ch.op;
            got.page = rsp_ch.physical_page;
            got.slot = rsp_ch.buffer_slot;
            got.owner = rsp_ch.moved_logical_page;
            got.last = rsp_ch.last;
            flash_book.check_result(got);
        end
    end

    // Sends one request, holding valid until the block takes it. Without a gap, valid stays
    // high across back-to-back items so it is never dropped and raised in one step.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [LP_W-1:0] lp,
                                input bit with_gaps);
        int gap;
        gap = with_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            req_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.command <= cmd;
        req_ch.logical_page <= lp;
        @(posedge i_clk iff req_ch.ready);
        flash_book.note_request(cmd, lp);
    endtask

    // Pauses the sender until every expected result has come back.
    task automatic drain_results();
        req_ch.valid <= 0;
        while (flash_book.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [LP_W-1:0] lp;
        int hot_base;
        sink_stalls = 1;
        i_rst_n = 0;
        req_ch.valid = 0;
        req_ch.command = CMD_GET;
        req_ch.logical_page = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed part: unmapped gets and removes, sets at the page extremes,
        // overwrite of a live mapping, the dropped command code, and a logical
        // page number with every bit set.
        send_request(CMD_GET, 10'd0, 0);
        send_request(CMD_REMOVE, 10'd1023, 0);
        send_request(CMD_SET, 10'd0, 0);
        send_request(CMD_SET, 10'd1023, 0);
        send_request(CMD_GET, 10'd0, 0);
        send_request(CMD_GET, 10'd1023, 1);
        send_request(CMD_SET, 10'd0, 1);
        send_request(CMD_NONE, 10'd512, 0);
        send_request(CMD_NONE, 10'd1023, 1);
        send_request(CMD_GET, 10'd0, 0);
        send_request(CMD_REMOVE, 10'd0, 0);
        send_request(CMD_REMOVE, 10'd0, 0);
        send_request(CMD_GET, 10'd0, 0);
        send_request(CMD_SET, 10'h2AA, 0);
        send_request(CMD_SET, 10'h155, 0);
        send_request(CMD_REMOVE, 10'h155, 1);
        send_request(CMD_GET, 10'h2AA, 1);

        // Pause until nothing is in flight, then turn sink stalls off for a while.
        drain_results();
        sink_stalls = 0;

        // Random part. Sets dominate; rewrites of a small hot set of logical
        // pages leave invalid pages behind, while the rest of the traffic
        // spans the full logical space.
        hot_base = $urandom_range(0, 1023 - 63);
        for (int i = 0; i < 403; i++) begin
            if (i == 100) sink_stalls = 1;
            if (i == 250) drain_results();
            case ($urandom_range(0, 9))
                0, 1: cmd = CMD_GET;
                2: cmd = CMD_REMOVE;
                3: cmd = ($urandom_range(0, 3) == 0) ? CMD_NONE : CMD_SET;
                default: cmd = CMD_SET;
            endcase
            if ($urandom_range(0, 2) == 0) lp = $urandom_range(0, 1023);
            else lp = hot_base + $urandom_range(0, 63);
            send_request(cmd, lp, (i % 200) >= 40);
        end

        req_ch.valid <= 0;
        while (flash_book.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (flash_book.errors == 0 && flash_book.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[page_map_ftl_greedy_gc_top.f]
+incdir+src
src/pmftl_pkg.sv
src/pmftl_ifs.sv
src/pmftl_ram.sv
src/pmftl_front.sv
src/pmftl_back.sv
src/page_map_ftl_greedy_gc_top.sv
tb/pmftl_tb_ifs.sv
tb/page_map_ftl_greedy_gc_top_tb.sv
